// ===== rtl/seh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seh_pkg
// Widths and shift amounts shared by the spring Hessian pipeline.
// ----------------------------------------------------------------------------
package seh_pkg;

    // coordinate, rest length, stiffness and result entry width
    localparam int COORD_W    = 32;
    // coordinate difference and its magnitude
    localparam int DIFF_W     = COORD_W + 1;
    // magnitude after prescaling, always below 2^31
    localparam int A_W        = COORD_W - 1;
    // multiplier operand and full product
    localparam int MUL_W      = 64;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MUL_STAGES = 3;
    // square root radicand and root
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = RAD_W / 2;
    // ratio scale (Q30) and unit-vector product scale (Q60)
    localparam int RATIO_SH   = 30;
    localparam int UNIT_SH    = 2 * RATIO_SH;
    // unit vector quotient bits and rest-length ratio quotient bits
    localparam int UQ_W       = RATIO_SH + 1;
    localparam int RQ_W       = COORD_W + RATIO_SH;
    // divisor of the ratio divide: root scaled back by up to two bits
    localparam int RDEN_W     = ROOT_W + 2;

    typedef logic [MUL_W-1:0]  mul_op_t;
    typedef logic [PROD_W-1:0] prod_t;

endpackage

// ===== rtl/seh_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seh_mul
// Multi-lane unsigned multiplier, split into four half-width partial
// products, three register stages, with a passing sideband.
// ----------------------------------------------------------------------------
module seh_mul #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1,
    parameter int OP_W   = seh_pkg::MUL_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [LANES-1:0][OP_W-1:0]     a,
    input  logic [LANES-1:0][OP_W-1:0]     b,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           out_valid,
    output logic [LANES-1:0][2*OP_W-1:0]   prod,
    output logic [SIDE_W-1:0]              side_out
);
    localparam int HALF_W = OP_W / 2;

    logic [2:0]                     valid_reg;
    logic [SIDE_W-1:0]              side1_reg;
    logic [SIDE_W-1:0]              side2_reg;
    logic [SIDE_W-1:0]              side3_reg;
    logic [LANES-1:0][OP_W-1:0]     p00_reg;
    logic [LANES-1:0][OP_W-1:0]     p01_reg;
    logic [LANES-1:0][OP_W-1:0]     p10_reg;
    logic [LANES-1:0][OP_W-1:0]     p11_reg;
    logic [LANES-1:0][OP_W:0]       mid_reg;
    logic [LANES-1:0][OP_W-1:0]     lo_reg;
    logic [LANES-1:0][OP_W-1:0]     hi_reg;
    logic [LANES-1:0][2*OP_W-1:0]   prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side_in;
        side2_reg <= side1_reg;
        side3_reg <= side2_reg;
        for (int l = 0; l < LANES; l++)
        begin
            // partial products
            p00_reg[l] <= OP_W'(a[l][HALF_W-1:0]) * OP_W'(b[l][HALF_W-1:0]);
            p01_reg[l] <= OP_W'(a[l][HALF_W-1:0]) * OP_W'(b[l][OP_W-1:HALF_W]);
            p10_reg[l] <= OP_W'(a[l][OP_W-1:HALF_W]) * OP_W'(b[l][HALF_W-1:0]);
            p11_reg[l] <= OP_W'(a[l][OP_W-1:HALF_W]) * OP_W'(b[l][OP_W-1:HALF_W]);
            // cross terms
            mid_reg[l] <= {1'b0, p01_reg[l]} + {1'b0, p10_reg[l]};
            lo_reg[l]  <= p00_reg[l];
            hi_reg[l]  <= p11_reg[l];
            // final combine
            prod_reg[l] <= {hi_reg[l], lo_reg[l]}
                         + {{(HALF_W-1){1'b0}}, mid_reg[l], {HALF_W{1'b0}}};
        end
    end

    assign out_valid = valid_reg[2];
    assign prod      = prod_reg;
    assign side_out  = side3_reg;

endmodule

// ===== rtl/seh_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seh_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module seh_sqrt #(
    parameter int SIDE_W = 1,
    parameter int RAD_W  = seh_pkg::RAD_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      radicand,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [RAD_W/2-1:0]    root,
    output logic [SIDE_W-1:0]     side_out
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int ACC_W  = REM_W + 2;

    logic [ROOT_W-1:0]  valid_reg;
    logic [REM_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];
    logic [RAD_W-1:0]   rad_reg  [ROOT_W];
    logic [SIDE_W-1:0]  side_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_stage
        logic               valid_prev;
        logic [REM_W-1:0]   rem_prev;
        logic [ROOT_W-1:0]  root_prev;
        logic [RAD_W-1:0]   rad_prev;
        logic [SIDE_W-1:0]  side_prev;
        logic [ACC_W-1:0]   acc;
        logic [ACC_W-1:0]   trial;
        logic [REM_W-1:0]   rem_next;
        logic [ROOT_W-1:0]  root_next;

        if (g == 0)
        begin : g_head
            assign valid_prev = in_valid;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = radicand;
            assign side_prev  = side_in;
        end
        else
        begin : g_link
            assign valid_prev = valid_reg[g-1];
            assign rem_prev   = rem_reg[g-1];
            assign root_prev  = root_reg[g-1];
            assign rad_prev   = rad_reg[g-1];
            assign side_prev  = side_reg[g-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb
        begin
            acc   = {rem_prev, rad_prev[RAD_W-1 -: 2]};
            trial = {2'b00, root_prev, 2'b01};
            if (acc >= trial)
            begin
                rem_next  = REM_W'(acc - trial);
                root_next = {root_prev[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(acc);
                root_next = {root_prev[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            root_reg[g] <= root_next;
            rad_reg[g]  <= rad_prev << 2;
            side_reg[g] <= side_prev;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

// ===== rtl/seh_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seh_div
// Pipelined restoring divider, one quotient bit per register stage, several
// lanes sharing one divisor. The starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
module seh_div #(
    parameter int LANES  = 1,
    parameter int QW     = seh_pkg::UQ_W,
    parameter int DW     = seh_pkg::ROOT_W,
    parameter int SIDE_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [DW-1:0]                divisor,
    input  logic [LANES-1:0][DW-1:0]     rem_init,
    input  logic [LANES-1:0][QW-1:0]     low_bits,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic [LANES-1:0][QW-1:0]     quot,
    output logic [SIDE_W-1:0]            side_out
);
    logic [QW-1:0]                  valid_reg;
    logic [DW-1:0]                  div_reg  [QW];
    logic [LANES-1:0][DW-1:0]       rem_reg  [QW];
    logic [LANES-1:0][QW-1:0]       low_reg  [QW];
    logic [LANES-1:0][QW-1:0]       quot_reg [QW];
    logic [SIDE_W-1:0]              side_reg [QW];

    for (genvar g = 0; g < QW; g++)
    begin : g_stage
        logic                       valid_prev;
        logic [DW-1:0]              div_prev;
        logic [LANES-1:0][DW-1:0]   rem_prev;
        logic [LANES-1:0][QW-1:0]   low_prev;
        logic [LANES-1:0][QW-1:0]   quot_prev;
        logic [SIDE_W-1:0]          side_prev;
        logic [LANES-1:0][DW:0]     acc;
        logic [LANES-1:0][DW-1:0]   rem_next;
        logic [LANES-1:0][QW-1:0]   quot_next;

        if (g == 0)
        begin : g_head
            assign valid_prev = in_valid;
            assign div_prev   = divisor;
            assign rem_prev   = rem_init;
            assign low_prev   = low_bits;
            assign quot_prev  = '0;
            assign side_prev  = side_in;
        end
        else
        begin : g_link
            assign valid_prev = valid_reg[g-1];
            assign div_prev   = div_reg[g-1];
            assign rem_prev   = rem_reg[g-1];
            assign low_prev   = low_reg[g-1];
            assign quot_prev  = quot_reg[g-1];
            assign side_prev  = side_reg[g-1];
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                acc[l] = {rem_prev[l], low_prev[l][QW-1]};
                if (acc[l] >= {1'b0, div_prev})
                begin
                    rem_next[l]  = DW'(acc[l] - {1'b0, div_prev});
                    quot_next[l] = {quot_prev[l][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l]  = DW'(acc[l]);
                    quot_next[l] = {quot_prev[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[g]  <= div_prev;
            rem_reg[g]  <= rem_next;
            quot_reg[g] <= quot_next;
            side_reg[g] <= side_prev;
            for (int l = 0; l < LANES; l++)
            begin
                low_reg[g][l] <= low_prev[l] << 1;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = quot_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// ===== rtl/spring_energy_hessian.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_energy_hessian
// Negated 3x3 Hessian block of a linear spring between two 3D particles.
// ----------------------------------------------------------------------------
// Fully pipelined: a new spring may be started in every clock cycle (busy is
// never raised) and its result appears with done, in start order. There is no
// output backpressure, so the receiver must take each result in its done
// cycle. The pipeline is built from the bit-per-stage units: 32 square root
// stages, 62 stages for the rest length ratio divide and 31 for the unit
// vector divide, plus three three-stage multiplier banks and seven single
// stages around them.
// Entries are h = -k[(1 - l0/l) I + (l0/l) u u^T] with u = d/l and d the
// first position minus the second; the full 6x6 block is [[h, -h], [-h, h]].
// Entries saturate to signed 32 bits (saturated flags a clip); coinciding
// points give degenerate with all entries zero. All values share one
// fixed-point scale, so the fraction width of the inputs carries through.
// ----------------------------------------------------------------------------
module spring_energy_hessian (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [seh_pkg::COORD_W-1:0]    first_x,
    input  logic signed [seh_pkg::COORD_W-1:0]    first_y,
    input  logic signed [seh_pkg::COORD_W-1:0]    first_z,
    input  logic signed [seh_pkg::COORD_W-1:0]    second_x,
    input  logic signed [seh_pkg::COORD_W-1:0]    second_y,
    input  logic signed [seh_pkg::COORD_W-1:0]    second_z,
    input  logic        [seh_pkg::COORD_W-1:0]    rest_length,
    input  logic        [seh_pkg::COORD_W-1:0]    spring_stiffness,
    output logic                                  done,
    output logic signed [seh_pkg::COORD_W-1:0]    h_xx,
    output logic signed [seh_pkg::COORD_W-1:0]    h_yy,
    output logic signed [seh_pkg::COORD_W-1:0]    h_zz,
    output logic signed [seh_pkg::COORD_W-1:0]    h_xy,
    output logic signed [seh_pkg::COORD_W-1:0]    h_xz,
    output logic signed [seh_pkg::COORD_W-1:0]    h_yz,
    output logic                                  degenerate,
    output logic                                  saturated
);
    import seh_pkg::*;

    localparam int LATENCY = 3 + 3 * MUL_STAGES + 1 + ROOT_W + RQ_W + UQ_W + 3;
    localparam logic [MUL_W-1:0] NEG_LIMIT = MUL_W'(1) << (COORD_W - 1);
    localparam logic [MUL_W-1:0] POS_LIMIT = NEG_LIMIT - MUL_W'(1);
    localparam logic [UNIT_SH:0] UNIT_SQ   = {1'b1, {UNIT_SH{1'b0}}};

    // sideband carried through the squares, sum and square root
    typedef struct packed {
        logic [2:0][A_W-1:0]   a;
        logic [2:0]            neg;
        logic [1:0]            scale;
        logic                  deg;
        logic [COORD_W-1:0]    l0;
        logic [COORD_W-1:0]    k;
    } side_a_t;

    // sideband through the ratio divide
    typedef struct packed {
        logic [2:0][A_W-1:0]   a;
        logic [2:0]            neg;
        logic [ROOT_W-1:0]     root;
        logic                  deg;
        logic [COORD_W-1:0]    k;
    } side_r_t;

    // sideband through the unit vector divide
    typedef struct packed {
        logic [RQ_W-1:0]       ratio;
        logic [2:0]            neg;
        logic                  deg;
        logic [COORD_W-1:0]    k;
    } side_u_t;

    // sideband through the product banks
    typedef struct packed {
        logic [2:0]            neg;
        logic                  deg;
        logic [COORD_W-1:0]    k;
    } side_m_t;

    // signed entry from sign and magnitude, clip flag on top
    function automatic logic [COORD_W:0] sat_pack(input logic neg,
                                                  input logic [MUL_W-1:0] mag);
        logic [COORD_W:0] res;
        if (neg)
        begin
            if (mag > NEG_LIMIT)
                res = {1'b1, COORD_W'(NEG_LIMIT)};
            else
                res = {1'b0, COORD_W'(-mag)};
        end
        else
        begin
            if (mag > POS_LIMIT)
                res = {1'b1, COORD_W'(POS_LIMIT)};
            else
                res = {1'b0, COORD_W'(mag)};
        end
        return res;
    endfunction

    logic accept;

    // stage 0: captured transaction
    logic                       v0_reg;
    logic signed [COORD_W-1:0]  first_reg  [3];
    logic signed [COORD_W-1:0]  second_reg [3];
    logic [COORD_W-1:0]         l0_0_reg;
    logic [COORD_W-1:0]         k_0_reg;

    // stage 1: difference magnitudes and signs
    logic signed [DIFF_W-1:0]   diff [3];
    logic [DIFF_W-1:0]          mag_next [3];
    logic                       v1_reg;
    logic [DIFF_W-1:0]          mag_reg [3];
    logic [2:0]                 neg1_reg;
    logic [COORD_W-1:0]         l0_1_reg;
    logic [COORD_W-1:0]         k_1_reg;

    // stage 2: prescale so every magnitude is below 2^31
    side_a_t                    sa_next;
    logic                       top2;
    logic                       top1;
    logic                       v2_reg;
    side_a_t                    sa_reg;

    // squares and their sum
    logic [2:0][MUL_W-1:0]      sq_op;
    logic                       sq_valid;
    logic [2:0][PROD_W-1:0]     sq_prod;
    side_a_t                    sq_side;
    logic                       vsum_reg;
    logic [RAD_W-1:0]           sum_reg;
    side_a_t                    ssum_reg;

    // square root
    logic                       rt_valid;
    logic [ROOT_W-1:0]          rt_root;
    side_a_t                    rt_side;

    // rest length ratio divide
    logic [RDEN_W-1:0]          rd_den;
    logic [0:0][RDEN_W-1:0]     rd_rem;
    logic [0:0][RQ_W-1:0]       rd_low;
    side_r_t                    rd_side_in;
    logic                       rd_valid;
    logic [0:0][RQ_W-1:0]       rd_quot;
    side_r_t                    rd_side;

    // unit vector divide
    logic [2:0][ROOT_W-1:0]     ud_rem;
    logic [2:0][UQ_W-1:0]       ud_low;
    side_u_t                    ud_side_in;
    logic                       ud_valid;
    logic [2:0][UQ_W-1:0]       ud_quot;
    side_u_t                    ud_side;

    // first product bank: k*R, u_i^2, u_i*u_j
    logic [6:0][MUL_W-1:0]      mb_a;
    logic [6:0][MUL_W-1:0]      mb_b;
    side_m_t                    mb_side_in;
    logic                       mb_valid;
    logic [6:0][PROD_W-1:0]     mb_prod;
    side_m_t                    mb_side;

    // operand preparation
    logic                       vprep_reg;
    logic [MUL_W-1:0]           t_reg;
    logic [2:0][UNIT_SH:0]      cpl_reg;
    logic [2:0][UNIT_SH:0]      cross_reg;
    side_m_t                    sprep_reg;

    // second product bank: T*(1 - u_i^2), T*u_i*u_j
    logic [5:0][MUL_W-1:0]      mc_a;
    logic [5:0][MUL_W-1:0]      mc_b;
    logic                       mc_valid;
    logic [5:0][PROD_W-1:0]     mc_prod;
    side_m_t                    mc_side;

    // sign and magnitude of each entry
    logic [MUL_W-1:0]           ent_mag_next [6];
    logic [5:0]                 ent_neg_next;
    logic [MUL_W-1:0]           g_val [3];
    logic [MUL_W-1:0]           m_val [3];
    logic [MUL_W-1:0]           k_ext;
    logic                       vsign_reg;
    logic [MUL_W-1:0]           ent_mag_reg [6];
    logic [5:0]                 ent_neg_reg;
    logic                       dsign_reg;

    // output register
    logic [COORD_W:0]           packed_ent [6];
    logic [5:0]                 clip;
    logic                       done_reg;
    logic [COORD_W-1:0]         h_reg [6];
    logic                       degenerate_reg;
    logic                       saturated_reg;

    // never stalls: the receiver takes every result as it appears
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------ valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vsum_reg  <= 1'b0;
            vprep_reg <= 1'b0;
            vsign_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v0_reg    <= accept;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            vsum_reg  <= sq_valid;
            vprep_reg <= mb_valid;
            vsign_reg <= mc_valid;
            done_reg  <= vsign_reg;
        end
    end

    // ---------------------------------------------------------- stage 0 .. 2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]     = DIFF_W'(first_reg[i]) - DIFF_W'(second_reg[i]);
            mag_next[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
        end
    end

    // shift of 0, 1 or 2 bits so that the squares sum below 2^64
    always_comb
    begin
        top2 = mag_reg[0][DIFF_W-1] | mag_reg[1][DIFF_W-1] | mag_reg[2][DIFF_W-1];
        top1 = mag_reg[0][DIFF_W-2] | mag_reg[1][DIFF_W-2] | mag_reg[2][DIFF_W-2];
        sa_next.scale = top2 ? 2'd2 : (top1 ? 2'd1 : 2'd0);
        for (int i = 0; i < 3; i++)
        begin
            sa_next.a[i] = A_W'(mag_reg[i] >> sa_next.scale);
        end
        sa_next.neg = neg1_reg;
        sa_next.deg = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        sa_next.l0  = l0_1_reg;
        sa_next.k   = k_1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg[0]  <= first_x;
            first_reg[1]  <= first_y;
            first_reg[2]  <= first_z;
            second_reg[0] <= second_x;
            second_reg[1] <= second_y;
            second_reg[2] <= second_z;
            l0_0_reg      <= rest_length;
            k_0_reg       <= spring_stiffness;
        end
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i]  <= mag_next[i];
            neg1_reg[i] <= diff[i][DIFF_W-1];
        end
        l0_1_reg <= l0_0_reg;
        k_1_reg  <= k_0_reg;
        sa_reg   <= sa_next;
    end

    // ------------------------------------------------- squared length, root
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_op[i] = MUL_W'(sa_reg.a[i]);
        end
    end

    seh_mul #(
        .LANES  (3),
        .SIDE_W ($bits(side_a_t)),
        .OP_W   (MUL_W)
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .a         (sq_op),
        .b         (sq_op),
        .side_in   (sa_reg),
        .out_valid (sq_valid),
        .prod      (sq_prod),
        .side_out  (sq_side)
    );

    always_ff @(posedge clk)
    begin
        sum_reg  <= sq_prod[0][RAD_W-1:0] + sq_prod[1][RAD_W-1:0]
                  + sq_prod[2][RAD_W-1:0];
        ssum_reg <= sq_side;
    end

    seh_sqrt #(
        .SIDE_W ($bits(side_a_t)),
        .RAD_W  (RAD_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vsum_reg),
        .radicand  (sum_reg),
        .side_in   (ssum_reg),
        .out_valid (rt_valid),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    // ------------------------------------------- l0 / l in Q30, then u in Q30
    always_comb
    begin
        rd_den              = RDEN_W'(rt_root) << rt_side.scale;
        rd_rem[0]           = '0;
        rd_low[0]           = {rt_side.l0, {RATIO_SH{1'b0}}};
        rd_side_in.a        = rt_side.a;
        rd_side_in.neg      = rt_side.neg;
        rd_side_in.root     = rt_root;
        rd_side_in.deg      = rt_side.deg;
        rd_side_in.k        = rt_side.k;
    end

    seh_div #(
        .LANES  (1),
        .QW     (RQ_W),
        .DW     (RDEN_W),
        .SIDE_W ($bits(side_r_t))
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .divisor   (rd_den),
        .rem_init  (rd_rem),
        .low_bits  (rd_low),
        .side_in   (rd_side_in),
        .out_valid (rd_valid),
        .quot      (rd_quot),
        .side_out  (rd_side)
    );

    // a_i <= l, so the top part of a_i * 2^30 already sits below the divisor
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ud_rem[i] = ROOT_W'(rd_side.a[i] >> 1);
            ud_low[i] = {rd_side.a[i][0], {RATIO_SH{1'b0}}};
        end
        ud_side_in.ratio = rd_quot[0];
        ud_side_in.neg   = rd_side.neg;
        ud_side_in.deg   = rd_side.deg;
        ud_side_in.k     = rd_side.k;
    end

    seh_div #(
        .LANES  (3),
        .QW     (UQ_W),
        .DW     (ROOT_W),
        .SIDE_W ($bits(side_u_t))
    ) u_unit_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid),
        .divisor   (rd_side.root),
        .rem_init  (ud_rem),
        .low_bits  (ud_low),
        .side_in   (ud_side_in),
        .out_valid (ud_valid),
        .quot      (ud_quot),
        .side_out  (ud_side)
    );

    // ------------------------------------------------------ first products
    always_comb
    begin
        mb_a[0] = MUL_W'(ud_side.k);
        mb_b[0] = MUL_W'(ud_side.ratio);
        for (int i = 0; i < 3; i++)
        begin
            mb_a[1+i] = MUL_W'(ud_quot[i]);
            mb_b[1+i] = MUL_W'(ud_quot[i]);
        end
        // xy, xz, yz
        mb_a[4] = MUL_W'(ud_quot[0]);
        mb_b[4] = MUL_W'(ud_quot[1]);
        mb_a[5] = MUL_W'(ud_quot[0]);
        mb_b[5] = MUL_W'(ud_quot[2]);
        mb_a[6] = MUL_W'(ud_quot[1]);
        mb_b[6] = MUL_W'(ud_quot[2]);
        mb_side_in.neg = ud_side.neg;
        mb_side_in.deg = ud_side.deg;
        mb_side_in.k   = ud_side.k;
    end

    seh_mul #(
        .LANES  (7),
        .SIDE_W ($bits(side_m_t)),
        .OP_W   (MUL_W)
    ) u_prod_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ud_valid),
        .a         (mb_a),
        .b         (mb_b),
        .side_in   (mb_side_in),
        .out_valid (mb_valid),
        .prod      (mb_prod),
        .side_out  (mb_side)
    );

    // T = k * l0 / l, and 1 - u_i^2 in Q60
    always_ff @(posedge clk)
    begin
        t_reg <= mb_prod[0][RATIO_SH +: MUL_W];
        for (int i = 0; i < 3; i++)
        begin
            cpl_reg[i]   <= UNIT_SQ - mb_prod[1+i][UNIT_SH:0];
            cross_reg[i] <= mb_prod[4+i][UNIT_SH:0];
        end
        sprep_reg <= mb_side;
    end

    // ----------------------------------------------------- second products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mc_a[i]   = t_reg;
            mc_b[i]   = MUL_W'(cpl_reg[i]);
            mc_a[3+i] = t_reg;
            mc_b[3+i] = MUL_W'(cross_reg[i]);
        end
    end

    seh_mul #(
        .LANES  (6),
        .SIDE_W ($bits(side_m_t)),
        .OP_W   (MUL_W)
    ) u_prod_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vprep_reg),
        .a         (mc_a),
        .b         (mc_b),
        .side_in   (sprep_reg),
        .out_valid (mc_valid),
        .prod      (mc_prod),
        .side_out  (mc_side)
    );

    // ------------------------------------------------- sign and magnitude
    always_comb
    begin
        k_ext = MUL_W'(mc_side.k);
        for (int i = 0; i < 3; i++)
        begin
            g_val[i] = mc_prod[i][UNIT_SH +: MUL_W];
            m_val[i] = mc_prod[3+i][UNIT_SH +: MUL_W];
            // diagonal: G - k
            if (g_val[i] >= k_ext)
            begin
                ent_mag_next[i] = g_val[i] - k_ext;
                ent_neg_next[i] = 1'b0;
            end
            else
            begin
                ent_mag_next[i] = k_ext - g_val[i];
                ent_neg_next[i] = 1'b1;
            end
            ent_mag_next[3+i] = m_val[i];
        end
        // off-diagonal is negative when both differences share a sign
        ent_neg_next[3] = (m_val[0] != '0) && (mc_side.neg[0] == mc_side.neg[1]);
        ent_neg_next[4] = (m_val[1] != '0) && (mc_side.neg[0] == mc_side.neg[2]);
        ent_neg_next[5] = (m_val[2] != '0) && (mc_side.neg[1] == mc_side.neg[2]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            ent_mag_reg[i] <= ent_mag_next[i];
        end
        ent_neg_reg <= ent_neg_next;
        dsign_reg   <= mc_side.deg;
    end

    // ------------------------------------------------ saturate and present
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            packed_ent[i] = sat_pack(ent_neg_reg[i], ent_mag_reg[i]);
            clip[i]       = packed_ent[i][COORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            h_reg[i] <= dsign_reg ? '0 : packed_ent[i][COORD_W-1:0];
        end
        degenerate_reg <= dsign_reg;
        saturated_reg  <= !dsign_reg && (clip != '0);
    end

    assign done       = done_reg;
    assign h_xx       = h_reg[0];
    assign h_yy       = h_reg[1];
    assign h_zz       = h_reg[2];
    assign h_xy       = h_reg[3];
    assign h_xz       = h_reg[4];
    assign h_yz       = h_reg[5];
    assign degenerate = degenerate_reg;
    assign saturated  = saturated_reg;

    // ------------------------------------------------------------ checks
    // every started transaction comes out after the fixed latency
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after fixed latency");

    // no result without a start the latency before
    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without matching start");

    // degenerate flag follows coinciding input points
    a_deg_source : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (degenerate == $past(first_x == second_x && first_y == second_y
                                      && first_z == second_z, LATENCY)))
        else $error("degenerate flag does not match inputs");

    // degenerate results are all zero and never flagged as clipped
    a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (h_xx == '0 && h_yy == '0 && h_zz == '0
                                  && h_xy == '0 && h_xz == '0 && h_yz == '0
                                  && !saturated))
        else $error("degenerate result not cleared");

endmodule
